### design/stc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg: session table shared definitions
// Codes, widths, constants and control structs used by the session table,
// its cells and its token generator.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int DEF_TABLE_DEPTH = 8;
    localparam int TOKEN_W         = 64;
    localparam int TIME_W          = 32;
    localparam int ROLE_W          = 2;
    localparam int MAX_W           = 4;
    localparam int CNT_OUT_W       = 4;
    localparam int APB_DW          = 32;
    localparam int APB_AW          = 3;
    localparam int LCG_STEPS       = 4;
    localparam int WORD_W          = 32;

    localparam logic [WORD_W-1:0] RAND_SEED        = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] LCG_MUL          = 32'd1664525;
    localparam logic [WORD_W-1:0] LCG_INC          = 32'd1013904223;
    localparam logic [TIME_W-1:0] DEF_TTL_MS       = 32'd600000;
    localparam logic [MAX_W-1:0]  DEF_MAX_SESSIONS = 4'd8;

    localparam logic [ROLE_W-1:0] ROLE_NONE  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_USER  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_ADMIN = 2'd2;

    typedef enum logic [1:0] {
        OP_LOGIN    = 2'd0,
        OP_VALIDATE = 2'd1,
        OP_LOGOUT   = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic {
        STAT_OK   = 1'b0,
        STAT_FAIL = 1'b1
    } t_status;

    typedef enum logic {
        REG_MAX_SESSIONS = 1'b0,
        REG_TTL_MS       = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_DECIDE,
        ST_RESP
    } t_state;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic clear_all;
        logic sweep;
        logic renew;
        logic remove;
        logic write;
    } t_cell_ctl;

    // handed from one cell to the next
    typedef struct packed {
        logic              hit_seen;
        logic              free_seen;
        logic              ok;
        logic [ROLE_W-1:0] role;
    } t_link;

    // expired when (now - expiry) read as signed is not negative
    function automatic logic is_expired(input logic [TIME_W-1:0] expiry,
                                        input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] diff;
        diff = now - expiry;
        return ~diff[TIME_W-1];
    endfunction

endpackage
`default_nettype wire

### design/stc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_req_if: session request channel
// Valid/ready channel carrying one login, validate or logout request.
// ----------------------------------------------------------------------------
interface stc_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [stc_pkg::ROLE_W-1:0]    role;
    logic [stc_pkg::TIME_W-1:0]    now_ms;
    logic [stc_pkg::TOKEN_W-1:0]   token_high;
    logic [stc_pkg::TOKEN_W-1:0]   token_low;

    modport source (
        output valid, operation, role, now_ms, token_high, token_low,
        input  ready
    );
    modport sink (
        input  valid, operation, role, now_ms, token_high, token_low,
        output ready
    );
endinterface
`default_nettype wire

### design/stc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_rsp_if: session result channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface stc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [stc_pkg::ROLE_W-1:0]     granted_role;
    logic [stc_pkg::TOKEN_W-1:0]    new_token_high;
    logic [stc_pkg::TOKEN_W-1:0]    new_token_low;
    logic [stc_pkg::CNT_OUT_W-1:0]  active_count;

    modport source (
        output valid, status, granted_role, new_token_high, new_token_low,
               active_count,
        input  ready
    );
    modport sink (
        input  valid, status, granted_role, new_token_high, new_token_low,
               active_count,
        output ready
    );
endinterface
`default_nettype wire

### design/session_table_with_ttl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// session_table_with_ttl: session table with sliding expiry
// Login, validate and logout against a row of session slots, with expired
// sessions dropped on login and 128-bit tokens drawn from an LCG.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  i_req     in         valid / ready    operation, role, now_ms, token_high/low
//  o_rsp     out        valid / ready    status, granted_role, new_token_*, count
//  apb       in         psel / penable   max_sessions (0x0), ttl_ms (0x4)
//
//  one request at a time; the gap from accept to the next accept is set by the
//  live count rippling through the slot row one slot per cycle, and by the
//  output taking the result; the four token words are drawn meanwhile.
//  synchronous active-low reset empties the table and reseeds the generator.
//  a held result does not block the next request until its own result is due.
//  a register write empties the table.
module session_table_with_ttl #(
    parameter int TABLE_DEPTH = stc_pkg::DEF_TABLE_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    stc_req_if.sink                          i_req,
    stc_rsp_if.source                        o_rsp,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [stc_pkg::APB_AW-1:0]        paddr,
    input  wire [stc_pkg::APB_DW-1:0]        pwdata,
    output logic [stc_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    import stc_pkg::*;

    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W    = ((CNT_W > MAX_W) ? CNT_W : MAX_W) + 1;
    localparam int WAIT_LEN = (TABLE_DEPTH > LCG_STEPS) ? TABLE_DEPTH : LCG_STEPS;
    localparam int WAIT_W   = $clog2(WAIT_LEN);

    // configuration
    logic [MAX_W-1:0]  r_max_sessions;
    logic [TIME_W-1:0] r_ttl_ms;
    logic              w_cfg_wr;
    t_reg_idx          w_reg_idx;

    // request and sequencing
    t_state             r_state;
    t_state             n_state;
    logic [WAIT_W-1:0]  r_wait;
    t_op                r_op;
    logic [ROLE_W-1:0]  r_role;
    logic [TIME_W-1:0]  r_now;
    logic [TOKEN_W-1:0] r_key_hi;
    logic [TOKEN_W-1:0] r_key_lo;
    logic [WORD_W-1:0]  r_rand;
    t_status            r_status;
    logic [ROLE_W-1:0]  r_grant;

    // result waiting to be pushed, and the output stage
    t_status            r_res_status;
    logic [ROLE_W-1:0]  r_res_role;
    logic [TOKEN_W-1:0] r_res_hi;
    logic [TOKEN_W-1:0] r_res_lo;
    logic [CNT_W-1:0]   r_res_cnt;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [ROLE_W-1:0]  r_out_role;
    logic [TOKEN_W-1:0] r_out_hi;
    logic [TOKEN_W-1:0] r_out_lo;
    logic [CNT_W-1:0]   r_out_cnt;

    t_cell_ctl          w_ctl;
    logic               w_in_ready;
    logic               w_accept;
    logic               w_push;
    logic               w_lcg_load;
    logic               w_lcg_step;
    logic               w_role_ok;
    logic               w_can_login;
    logic               w_do_write;
    logic [LIM_W-1:0]   w_limit;
    logic [TIME_W-1:0]  w_new_expiry;
    logic [WORD_W-1:0]  w_lcg_state;
    logic [4*WORD_W-1:0] w_draw;

    t_link              w_link [TABLE_DEPTH+1];
    logic [CNT_W-1:0]   w_cnt  [TABLE_DEPTH+1];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            REG_MAX_SESSIONS: prdata = APB_DW'(r_max_sessions);
            REG_TTL_MS:       prdata = APB_DW'(r_ttl_ms);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sessions <= DEF_MAX_SESSIONS;
            r_ttl_ms       <= DEF_TTL_MS;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_MAX_SESSIONS: r_max_sessions <= pwdata[MAX_W-1:0];
                REG_TTL_MS:       r_ttl_ms       <= pwdata[TIME_W-1:0];
                default:          r_ttl_ms       <= r_ttl_ms;
            endcase
        end
    end

    // ---------------- decisions ----------------
    assign w_role_ok    = (r_role == ROLE_USER) || (r_role == ROLE_ADMIN);
    assign w_new_expiry = r_now + r_ttl_ms;

    always_comb begin
        w_limit = LIM_W'(r_max_sessions);
        if (w_limit == '0) begin
            w_limit = LIM_W'(1);
        end else if (w_limit > LIM_W'(TABLE_DEPTH)) begin
            w_limit = LIM_W'(TABLE_DEPTH);
        end
    end

    assign w_can_login = LIM_W'(w_cnt[TABLE_DEPTH]) < w_limit;
    assign w_do_write  = (r_op == OP_LOGIN) && w_role_ok && w_can_login;
    assign w_accept    = i_req.valid && w_in_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_EXEC;
            ST_EXEC:   n_state = ST_WAIT;
            ST_WAIT:   if (r_wait == WAIT_W'(WAIT_LEN - 1)) n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_RESP;
            ST_RESP:   if (w_push) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl           = '0;
        w_ctl.clear_all = w_cfg_wr;
        w_in_ready      = 1'b0;
        w_push          = 1'b0;
        w_lcg_load      = 1'b0;
        w_lcg_step      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_EXEC: begin
                w_ctl.sweep  = (r_op == OP_LOGIN) && w_role_ok;
                w_ctl.renew  = (r_op == OP_VALIDATE);
                w_ctl.remove = (r_op == OP_LOGOUT);
                w_lcg_load   = 1'b1;
            end
            ST_WAIT: begin
                w_lcg_step = {1'b0, r_wait} < (WAIT_W + 1)'(LCG_STEPS);
            end
            ST_DECIDE: begin
                w_ctl.write = w_do_write;
            end
            ST_RESP: begin
                w_push = !r_out_valid || o_rsp.ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= '0;
            r_rand      <= RAND_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) begin
                r_wait <= '0;
            end else if (r_state == ST_WAIT) begin
                r_wait <= r_wait + WAIT_W'(1);
            end
            if (w_ctl.write) begin
                r_rand <= w_lcg_state;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= t_op'(i_req.operation);
            r_role   <= i_req.role;
            r_now    <= i_req.now_ms;
            r_key_hi <= i_req.token_high;
            r_key_lo <= i_req.token_low;
        end
        if (r_state == ST_EXEC) begin
            priority if (r_op == OP_VALIDATE && w_link[TABLE_DEPTH].ok) begin
                r_status <= STAT_OK;
                r_grant  <= w_link[TABLE_DEPTH].role;
            end else if (r_op == OP_LOGOUT && w_link[TABLE_DEPTH].hit_seen) begin
                r_status <= STAT_OK;
                r_grant  <= ROLE_NONE;
            end else begin
                r_status <= STAT_FAIL;
                r_grant  <= ROLE_NONE;
            end
        end
        if (r_state == ST_DECIDE) begin
            if (w_do_write) begin
                r_res_status <= STAT_OK;
                r_res_role   <= ROLE_NONE;
                r_res_hi     <= w_draw[4*WORD_W-1:2*WORD_W];
                r_res_lo     <= w_draw[2*WORD_W-1:0];
                r_res_cnt    <= w_cnt[TABLE_DEPTH] + CNT_W'(1);
            end else begin
                r_res_status <= (r_op == OP_LOGIN) ? STAT_FAIL : r_status;
                r_res_role   <= r_grant;
                r_res_hi     <= '0;
                r_res_lo     <= '0;
                r_res_cnt    <= w_cnt[TABLE_DEPTH];
            end
        end
        if (w_push) begin
            r_out_status <= r_res_status;
            r_out_role   <= r_res_role;
            r_out_hi     <= r_res_hi;
            r_out_lo     <= r_res_lo;
            r_out_cnt    <= r_res_cnt;
        end
    end

    // ---------------- slot row ----------------
    assign w_link[0] = '0;
    assign w_cnt[0]  = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        stc_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_now        (r_now),
            .i_new_expiry (w_new_expiry),
            .i_key_hi     (r_key_hi),
            .i_key_lo     (r_key_lo),
            .i_wr_hi      (w_draw[4*WORD_W-1:2*WORD_W]),
            .i_wr_lo      (w_draw[2*WORD_W-1:0]),
            .i_wr_role    (r_role),
            .i_link       (w_link[g]),
            .i_cnt        (w_cnt[g]),
            .o_link       (w_link[g+1]),
            .o_cnt        (w_cnt[g+1])
        );
    end

    stc_lcg u_lcg (
        .i_clk   (i_clk),
        .i_load  (w_lcg_load),
        .i_seed  (r_rand),
        .i_step  (w_lcg_step),
        .o_state (w_lcg_state),
        .o_draw  (w_draw)
    );

    // ---------------- ports ----------------
    assign i_req.ready          = w_in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.granted_role   = r_out_role;
    assign o_rsp.new_token_high = r_out_hi;
    assign o_rsp.new_token_low  = r_out_lo;
    assign o_rsp.active_count   = CNT_OUT_W'(r_out_cnt);

    // ---------------- checks ----------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_EXEC)
        else $error("accepted request did not start execution");

    a_write_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.write |-> w_link[TABLE_DEPTH].free_seen)
        else $error("login write with no free slot");

    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.granted_role != ROLE_NONE) |-> o_rsp.status == STAT_OK)
        else $error("role granted on a refused request");

    a_token_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.new_token_high != '0 || o_rsp.new_token_low != '0))
            |-> o_rsp.status == STAT_OK)
        else $error("token returned on a refused request");

endmodule
`default_nettype wire

### design/stc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_cell: one session slot
// Holds one session and its live flag, matches the search token locally,
// passes first-match and first-free marks on to the next slot and keeps a
// running live count that moves one slot per cycle.
// ----------------------------------------------------------------------------
module stc_cell #(
    parameter int CNT_W = 4
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire stc_pkg::t_cell_ctl        i_ctl,
    input  wire [stc_pkg::TIME_W-1:0]      i_now,
    input  wire [stc_pkg::TIME_W-1:0]      i_new_expiry,
    input  wire [stc_pkg::TOKEN_W-1:0]     i_key_hi,
    input  wire [stc_pkg::TOKEN_W-1:0]     i_key_lo,
    input  wire [stc_pkg::TOKEN_W-1:0]     i_wr_hi,
    input  wire [stc_pkg::TOKEN_W-1:0]     i_wr_lo,
    input  wire [stc_pkg::ROLE_W-1:0]      i_wr_role,
    input  wire stc_pkg::t_link            i_link,
    input  wire [CNT_W-1:0]                i_cnt,
    output stc_pkg::t_link                 o_link,
    output logic [CNT_W-1:0]               o_cnt
);
    import stc_pkg::*;

    logic               r_valid;
    logic [TOKEN_W-1:0] r_tok_hi;
    logic [TOKEN_W-1:0] r_tok_lo;
    logic [ROLE_W-1:0]  r_role;
    logic [TIME_W-1:0]  r_expiry;
    logic [CNT_W-1:0]   r_cnt;

    logic w_match;
    logic w_hit;
    logic w_free;
    logic w_expired;

    assign w_match   = r_valid && (r_tok_hi == i_key_hi) && (r_tok_lo == i_key_lo);
    assign w_hit     = w_match && !i_link.hit_seen;
    assign w_free    = !r_valid && !i_link.free_seen;
    assign w_expired = is_expired(r_expiry, i_now);

    always_comb begin
        o_link.hit_seen  = i_link.hit_seen | w_match;
        o_link.free_seen = i_link.free_seen | !r_valid;
        o_link.ok        = w_hit ? !w_expired : i_link.ok;
        o_link.role      = w_hit ? r_role : i_link.role;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= i_cnt + CNT_W'(r_valid);
            if (i_ctl.clear_all) begin
                r_valid <= 1'b0;
            end else if (i_ctl.sweep && r_valid && w_expired) begin
                r_valid <= 1'b0;
            end else if (i_ctl.remove && w_hit) begin
                r_valid <= 1'b0;
            end else if (i_ctl.write && w_free) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && w_free && !i_ctl.clear_all) begin
            r_tok_hi <= i_wr_hi;
            r_tok_lo <= i_wr_lo;
            r_role   <= i_wr_role;
            r_expiry <= i_new_expiry;
        end else if (i_ctl.renew && w_hit && !w_expired) begin
            r_expiry <= i_new_expiry;
        end
    end

    assign o_cnt = r_cnt;

endmodule
`default_nettype wire

### design/stc_lcg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_lcg: token word generator
// 32-bit linear congruential generator, one step per cycle while i_step is high,
// collecting the drawn words into a 128-bit token.
// ----------------------------------------------------------------------------
module stc_lcg (
    input  wire                              i_clk,
    input  wire                              i_load,
    input  wire [stc_pkg::WORD_W-1:0]        i_seed,
    input  wire                              i_step,
    output logic [stc_pkg::WORD_W-1:0]       o_state,
    output logic [4*stc_pkg::WORD_W-1:0]     o_draw
);
    import stc_pkg::*;

    logic [WORD_W-1:0]   r_state;
    logic [4*WORD_W-1:0] r_draw;
    logic [WORD_W-1:0]   w_next;

    assign w_next = r_state * LCG_MUL + LCG_INC;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_state <= i_seed;
        end else if (i_step) begin
            r_state <= w_next;
            r_draw  <= {r_draw[3*WORD_W-1:0], w_next};
        end
    end

    assign o_state = r_state;
    assign o_draw  = r_draw;

endmodule
`default_nettype wire
